FILE: hw/rtl/dryth_pkg.sv
// dryth_pkg: shared types, codes, register reset values and profile rom
// for the dryer heater thermostat; no dependencies
`default_nettype none

package dryth_pkg;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_SAMPLE = 3'd1,
    REQ_START  = 3'd2,
    REQ_MON    = 3'd3,
    REQ_MOFF   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_AUTO = 2'd1,
    MODE_MON  = 2'd2,
    MODE_MOFF = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RSN_BOOT     = 3'd0,
    RSN_TIMEOUT  = 3'd1,
    RSN_OVERTEMP = 3'd2,
    RSN_IDLE     = 3'd3,
    RSN_MANUAL   = 3'd4,
    RSN_DONE     = 3'd5,
    RSN_HEAT     = 3'd6,
    RSN_HOLD     = 3'd7
  } reason_t;

  typedef enum logic [1:0] {
    CFG_MAX_TEMP   = 2'd0,
    CFG_SENSOR_TMO = 2'd1,
    CFG_MANUAL_TMO = 2'd2
  } cfg_idx_t;

  localparam logic signed [11:0] MAX_TEMP_RST   = 12'sd700;
  localparam logic [31:0]        SENSOR_TMO_RST = 32'd10000;
  localparam logic [31:0]        MANUAL_TMO_RST = 32'd3600000;

  localparam logic [2:0]         ROM_ENTRIES = 3'd6;
  localparam logic signed [11:0] HYST_TENTHS = 12'sd20;

  // remaining time: saturate at 6 h, else floor(ms/1000) = floor((ms>>3)/125)
  localparam logic [14:0] REM_MAX      = 15'd21600;
  localparam logic [31:0] REM_SAT_MS   = 32'd21600000;
  localparam int          DIV_IN_W     = 22;
  localparam logic [22:0] RECIP_125    = 23'd4294968;
  localparam int          RECIP_SHIFT  = 29;
  localparam int          PROD_W       = 45;

  typedef struct packed {
    logic        relay;
    logic [1:0]  mode;
    logic [2:0]  reason;
    logic        fault;
    logic        ok;
  } status_t;

  typedef struct packed {
    status_t     st;
    logic        timed;
    logic [31:0] now;
    logic [31:0] start;
    logic [31:0] period;
  } snap_t;

  function automatic logic signed [11:0] rom_target(input logic [2:0] idx);
    logic signed [11:0] t;
    case (idx)
      3'd0:    t = 12'sd450;
      3'd1:    t = 12'sd550;
      3'd2:    t = 12'sd600;
      3'd3:    t = 12'sd600;
      3'd4:    t = 12'sd500;
      3'd5:    t = 12'sd650;
      default: t = 12'sd450;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] rom_dur(input logic [2:0] idx);
    logic [31:0] d;
    case (idx)
      3'd0:    d = 32'd7200000;
      3'd1:    d = 32'd14400000;
      3'd2:    d = 32'd10800000;
      3'd3:    d = 32'd14400000;
      3'd4:    d = 32'd14400000;
      3'd5:    d = 32'd21600000;
      default: d = 32'd7200000;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dryth_core.sv
// dryth_core: request register, thermostat state, config registers and
// next-state rules; depends on dryth_pkg
`default_nettype none

module dryth_core #(
  parameter int PROFILE_COUNT = 6
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [2:0]              in_req_type,
  input  wire  [31:0]             in_now_ms,
  input  wire  signed [11:0]      in_temp_tenths,
  input  wire                     in_sample_valid,
  input  wire  [2:0]              in_profile_index,
  input  wire                     cfg_valid,
  input  wire  [1:0]              cfg_index,
  input  wire  [31:0]             cfg_data,
  output logic                    snap_valid,
  input  wire                     snap_ready,
  output dryth_pkg::snap_t        snap
);
  import dryth_pkg::*;

  // request register
  logic               s0_valid_r;
  logic [2:0]         s0_req_r;
  logic [31:0]        s0_now_r;
  logic signed [11:0] s0_temp_r;
  logic               s0_sv_r;
  logic [2:0]         s0_idx_r;

  // config
  logic signed [11:0] max_temp_r;
  logic [31:0]        sensor_tmo_r;
  logic [31:0]        manual_tmo_r;

  // architectural state
  logic [1:0]         mode_r, mode_nxt;
  logic               heater_r, heater_nxt;
  logic               fault_r, fault_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  logic [31:0]        valid_ms_r, valid_ms_nxt;
  logic [31:0]        start_r, start_nxt;
  logic [2:0]         prof_r, prof_nxt;
  logic [2:0]         reason_r, reason_nxt;
  logic               ok;

  logic               fire;
  logic               idx_ok;
  logic [31:0]        since_valid;
  logic [31:0]        since_start;
  logic signed [11:0] tgt;
  logic signed [11:0] tgt_lo;

  assign fire     = s0_valid_r && snap_ready;
  assign in_ready = !s0_valid_r || snap_ready;

  assign idx_ok = ({1'b0, s0_idx_r} < 4'(PROFILE_COUNT)) && (s0_idx_r < ROM_ENTRIES);
  assign since_valid = s0_now_r - valid_ms_r;
  assign since_start = s0_now_r - start_r;
  assign tgt    = rom_target(prof_r);
  assign tgt_lo = tgt - HYST_TENTHS;

  always_comb begin
    mode_nxt     = mode_r;
    heater_nxt   = heater_r;
    fault_nxt    = fault_r;
    temp_nxt     = temp_r;
    valid_ms_nxt = valid_ms_r;
    start_nxt    = start_r;
    prof_nxt     = prof_r;
    reason_nxt   = reason_r;
    ok           = 1'b1;
    unique case (s0_req_r)
      REQ_TICK: begin
        if (since_valid > sensor_tmo_r) begin
          fault_nxt  = 1'b1;
          mode_nxt   = MODE_IDLE;
          heater_nxt = 1'b0;
          reason_nxt = RSN_TIMEOUT;
        end else if (temp_r >= max_temp_r) begin
          mode_nxt   = MODE_IDLE;
          heater_nxt = 1'b0;
          reason_nxt = RSN_OVERTEMP;
        end else if (mode_r == MODE_MON) begin
          if (since_start > manual_tmo_r) begin
            mode_nxt   = MODE_IDLE;
            heater_nxt = 1'b0;
          end else begin
            heater_nxt = 1'b1;
            reason_nxt = RSN_MANUAL;
          end
        end else if (mode_r == MODE_AUTO) begin
          if (since_start > rom_dur(prof_r)) begin
            mode_nxt   = MODE_IDLE;
            heater_nxt = 1'b0;
            reason_nxt = RSN_DONE;
          end else if (temp_r < tgt_lo) begin
            heater_nxt = 1'b1;
            reason_nxt = RSN_HEAT;
          end else if (temp_r >= tgt) begin
            heater_nxt = 1'b0;
            reason_nxt = RSN_HOLD;
          end
        end else begin
          heater_nxt = 1'b0;
          reason_nxt = RSN_IDLE;
        end
      end
      REQ_SAMPLE: begin
        if (s0_sv_r) begin
          temp_nxt     = s0_temp_r;
          valid_ms_nxt = s0_now_r;
          fault_nxt    = 1'b0;
        end
      end
      REQ_START: begin
        if (idx_ok) begin
          prof_nxt  = s0_idx_r;
          mode_nxt  = MODE_AUTO;
          start_nxt = s0_now_r;
        end else begin
          ok = 1'b0;
        end
      end
      REQ_MON: begin
        mode_nxt  = MODE_MON;
        start_nxt = s0_now_r;
      end
      REQ_MOFF: mode_nxt = MODE_MOFF;
      default: ;
    endcase
  end

  // snapshot of the status after this request, plus what the remaining
  // time pipeline needs
  always_comb begin
    snap_valid      = s0_valid_r;
    snap.st.relay   = heater_nxt;
    snap.st.mode    = mode_nxt;
    snap.st.reason  = reason_nxt;
    snap.st.fault   = fault_nxt;
    snap.st.ok      = ok;
    snap.timed      = (mode_nxt == MODE_AUTO) || (mode_nxt == MODE_MON);
    snap.now        = s0_now_r;
    snap.start      = start_nxt;
    snap.period     = (mode_nxt == MODE_AUTO) ? rom_dur(prof_nxt) : manual_tmo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      max_temp_r   <= MAX_TEMP_RST;
      sensor_tmo_r <= SENSOR_TMO_RST;
      manual_tmo_r <= MANUAL_TMO_RST;
      mode_r       <= MODE_IDLE;
      heater_r     <= 1'b0;
      fault_r      <= 1'b0;
      temp_r       <= '0;
      valid_ms_r   <= '0;
      start_r      <= '0;
      prof_r       <= '0;
      reason_r     <= RSN_BOOT;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_TEMP:   max_temp_r   <= signed'(cfg_data[11:0]);
          CFG_SENSOR_TMO: sensor_tmo_r <= cfg_data;
          CFG_MANUAL_TMO: manual_tmo_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        mode_r     <= mode_nxt;
        heater_r   <= heater_nxt;
        fault_r    <= fault_nxt;
        temp_r     <= temp_nxt;
        valid_ms_r <= valid_ms_nxt;
        start_r    <= start_nxt;
        prof_r     <= prof_nxt;
        reason_r   <= reason_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_req_r  <= in_req_type;
      s0_now_r  <= in_now_ms;
      s0_temp_r <= in_temp_tenths;
      s0_sv_r   <= in_sample_valid;
      s0_idx_r  <= in_profile_index;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dryth_rem.sv
// dryth_rem: remaining-seconds pipeline and result register
// (elapsed, difference and saturation, reciprocal multiply); depends on dryth_pkg
`default_nettype none

module dryth_rem (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                snap_valid,
  output logic               snap_ready,
  input  dryth_pkg::snap_t   snap,
  output logic               out_valid,
  input  wire                out_ready,
  output dryth_pkg::status_t out_st,
  output logic [14:0]        out_rem
);
  import dryth_pkg::*;

  logic                s1_v_r, s2_v_r, s3_v_r, o_v_r;
  logic                s1_rdy, s2_rdy, s3_rdy, o_rdy;

  snap_t               s1_r;
  status_t             s2_st_r, s3_st_r, o_st_r;
  logic                s2_timed_r;
  logic [31:0]         s2_el_r, s2_period_r;
  logic                s3_zero_r, s3_sat_r;
  logic [DIV_IN_W-1:0] s3_q_r;
  logic [14:0]         o_rem_r;

  logic [31:0]         rem_ms;
  logic [PROD_W-1:0]   prod;
  logic [14:0]         rem_nxt;

  assign o_rdy      = !o_v_r || out_ready;
  assign s3_rdy     = !s3_v_r || o_rdy;
  assign s2_rdy     = !s2_v_r || s3_rdy;
  assign s1_rdy     = !s1_v_r || s2_rdy;
  assign snap_ready = s1_rdy;

  assign rem_ms  = s2_period_r - s2_el_r;
  assign prod    = PROD_W'(s3_q_r) * PROD_W'(RECIP_125);
  assign rem_nxt = s3_zero_r ? 15'd0 :
                   s3_sat_r  ? REM_MAX : prod[RECIP_SHIFT+14:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= snap_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (o_rdy)  o_v_r  <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && snap_valid) begin
      s1_r <= snap;
    end
    if (s2_rdy && s1_v_r) begin
      s2_st_r     <= s1_r.st;
      s2_timed_r  <= s1_r.timed;
      s2_el_r     <= s1_r.now - s1_r.start;
      s2_period_r <= s1_r.period;
    end
    if (s3_rdy && s2_v_r) begin
      s3_st_r   <= s2_st_r;
      s3_zero_r <= !s2_timed_r || (s2_period_r <= s2_el_r);
      s3_sat_r  <= rem_ms >= REM_SAT_MS;
      s3_q_r    <= rem_ms[DIV_IN_W+2:3];
    end
    if (o_rdy && s3_v_r) begin
      o_st_r  <= s3_st_r;
      o_rem_r <= rem_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_st    = o_st_r;
  assign out_rem   = o_rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dryer_heater_thermostat_unit.sv
// dryer_heater_thermostat_unit: top level of the heater thermostat
// depends on dryth_pkg, dryth_core and dryth_rem
//
// usage
//   in_*  : one request per handshake (tick, sensor sample, start profile,
//           manual on, manual off), each with its millisecond timestamp
//   out_* : exactly one status result per request, in request order
//   cfg_* : register writes (0 max temp, 1 sensor timeout, 2 manual timeout),
//           always ready, taken in the cycle they are offered
// pipeline: an accepted request passes through state update into the
//   snapshot register, elapsed time, difference and saturation, and
//   reciprocal multiply into the result register
// throughput: one request per cycle while no result stalls; state is updated
//   straight out of the request register, so back-to-back requests see each
//   other's effects
// stall: every stage has its own valid and moves up into free slots, so
//   requests keep being taken until the pipeline is full behind a stalled
//   result; in_ready is high whenever no result is waiting
// reset: synchronous, active low; mode idle, relay off, reason booting,
//   config back to 70.0 C, 10 s sensor timeout and 1 h manual timeout
`default_nettype none

module dryer_heater_thermostat_unit #(
  parameter int PROFILE_COUNT = 6
) (
  input  wire                clk,
  input  wire                rst_n,
  // request channel
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         in_req_type,
  input  wire  [31:0]        in_now_ms,
  input  wire  signed [11:0] in_temp_tenths,
  input  wire                in_sample_valid,
  input  wire  [2:0]         in_profile_index,
  // result channel
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_relay_on,
  output logic [1:0]         out_mode,
  output logic [2:0]         out_reason,
  output logic               out_sensor_fault,
  output logic [14:0]        out_remaining_s,
  output logic               out_cmd_ok,
  // configuration write channel
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data
);
  import dryth_pkg::*;

  snap_t   snap;
  logic    snap_valid;
  logic    snap_ready;
  status_t out_st;

  // config registers are plain flops, a write never waits
  assign cfg_ready = 1'b1;

  // request register, thermostat state and next-state rules
  dryth_core #(
    .PROFILE_COUNT (PROFILE_COUNT)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_now_ms        (in_now_ms),
    .in_temp_tenths   (in_temp_tenths),
    .in_sample_valid  (in_sample_valid),
    .in_profile_index (in_profile_index),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .snap_valid       (snap_valid),
    .snap_ready       (snap_ready),
    .snap             (snap)
  );

  // remaining-seconds pipeline ending in the result register
  dryth_rem u_rem (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_st     (out_st),
    .out_rem    (out_remaining_s)
  );

  assign out_relay_on     = out_st.relay;
  assign out_mode         = out_st.mode;
  assign out_reason       = out_st.reason;
  assign out_sensor_fault = out_st.fault;
  assign out_cmd_ok       = out_st.ok;

`ifndef SYNTHESIS
  // every way into idle drops the relay
  a_idle_relay_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_IDLE) |-> !out_relay_on)
    else $error("relay on while idle");

  // no timed period outside auto and manual on
  a_untimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_mode == MODE_IDLE) || (out_mode == MODE_MOFF))
      |-> (out_remaining_s == 15'd0))
    else $error("remaining time outside a timed mode");

  // saturation bound of the remaining-time reciprocal multiply
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_remaining_s <= REM_MAX))
    else $error("remaining time above saturation");

  // with the result register empty the whole pipeline drains forward
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with empty result register");
`endif

endmodule

`default_nettype wire

FILE: sim/dryer_heater_thermostat_unit_test.sv
// dryer_heater_thermostat_unit_test: self-checking testbench for the heater thermostat
// predicts the status after every request and compares it field by field
// depends on dryth_pkg and dryer_heater_thermostat_unit
module dryer_heater_thermostat_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dryth_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int GAP_MAX       = 6;
  // settle after the last result before register writes
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PROFILE_TOTAL = 6;

  // request codes past manual off are undefined and only report status
  localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
  // register index with nothing behind it
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  localparam logic signed [11:0] TEMP_MIN = -12'sd400;
  localparam logic signed [11:0] TEMP_MAX = 12'sd1250;

  typedef struct {
    logic        relay;
    mode_t       mode;
    reason_t     reason;
    logic        fault;
    logic [14:0] secs;
    logic        ok;
  } heater_status_t;

  // drying profiles: target in tenths of a degree and run time in ms
  int          profile_target [PROFILE_TOTAL] = '{450, 550, 600, 600, 500, 650};
  logic [31:0] profile_ms [PROFILE_TOTAL] =
    '{32'd7200000, 32'd14400000, 32'd10800000, 32'd14400000, 32'd14400000, 32'd21600000};

  // clock, reset and ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = '0;
  logic [31:0]        in_now_ms = '0;
  logic signed [11:0] in_temp_tenths = '0;
  logic               in_sample_valid = 1'b0;
  logic [2:0]         in_profile_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_relay_on;
  logic [1:0]         out_mode;
  logic [2:0]         out_reason;
  logic               out_sensor_fault;
  logic [14:0]        out_remaining_s;
  logic               out_cmd_ok;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // thermostat state as predicted, starting from the reset values
  mode_t              th_mode = MODE_IDLE;
  logic               th_heat = 1'b0;
  logic               th_fault = 1'b0;
  logic signed [11:0] th_temp = '0;
  logic [31:0]        th_seen_ms = '0;
  logic [31:0]        th_start_ms = '0;
  logic [2:0]         th_profile = '0;
  reason_t            th_reason = RSN_BOOT;

  // register copies
  logic signed [11:0] cut_temp = MAX_TEMP_RST;
  logic [31:0]        sensor_limit_ms = SENSOR_TMO_RST;
  logic [31:0]        manual_limit_ms = MANUAL_TMO_RST;

  heater_status_t status_due [$];
  logic [31:0]    wall_ms = '0;
  bit             steady = 1'b0;   // both sides run without gaps while set
  int             errors = 0;
  int             requests_sent = 0;
  int             results_seen = 0;
  int             settings_used = 1;
  int             cycle_count = 0;
  int             reason_hits [8] = '{default: 0};

  dryer_heater_thermostat_unit u_dut (.*);

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // apply one request to the predicted state and return the status it reports
  function automatic heater_status_t heater_status_after(input logic [2:0] req,
      input logic [31:0] now, input logic signed [11:0] temp, input logic sample_ok,
      input logic [2:0] idx);
    heater_status_t st;
    int             cur;
    int             target;
    logic [31:0]    period;
    logic [31:0]    elapsed;
    logic [31:0]    left;
    st.ok = 1'b1;
    case (req)
      REQ_TICK: begin
        cur = th_temp;
        target = profile_target[th_profile];
        // safety first: stale sensor, then overtemperature
        if (now - th_seen_ms > sensor_limit_ms) begin
          th_fault = 1'b1;
          th_mode = MODE_IDLE;
          th_heat = 1'b0;
          th_reason = RSN_TIMEOUT;
        end else if (th_temp >= cut_temp) begin
          th_mode = MODE_IDLE;
          th_heat = 1'b0;
          th_reason = RSN_OVERTEMP;
        end else if (th_mode == MODE_MON) begin
          // manual expiry keeps the old reason until the next tick
          if (now - th_start_ms > manual_limit_ms) begin
            th_mode = MODE_IDLE;
            th_heat = 1'b0;
          end else begin
            th_heat = 1'b1;
            th_reason = RSN_MANUAL;
          end
        end else if (th_mode == MODE_AUTO) begin
          if (now - th_start_ms > profile_ms[th_profile]) begin
            th_mode = MODE_IDLE;
            th_heat = 1'b0;
            th_reason = RSN_DONE;
          end else if (cur < target - HYST_TENTHS) begin
            th_heat = 1'b1;
            th_reason = RSN_HEAT;
          end else if (cur >= target) begin
            th_heat = 1'b0;
            th_reason = RSN_HOLD;
          end
          // inside the hysteresis band relay and reason stay as they are
        end else begin
          th_heat = 1'b0;
          th_reason = RSN_IDLE;
        end
      end
      REQ_SAMPLE: begin
        if (sample_ok) begin
          th_temp = temp;
          th_seen_ms = now;
          th_fault = 1'b0;
        end
      end
      REQ_START: begin
        if (idx < PROFILE_TOTAL) begin
          th_profile = idx;
          th_mode = MODE_AUTO;
          th_start_ms = now;
        end else begin
          st.ok = 1'b0;
        end
      end
      REQ_MON: begin
        th_mode = MODE_MON;
        th_start_ms = now;
      end
      REQ_MOFF: th_mode = MODE_MOFF;
      default: ;
    endcase
    period = (th_mode == MODE_AUTO) ? profile_ms[th_profile] : manual_limit_ms;
    elapsed = now - th_start_ms;
    st.secs = '0;
    if ((th_mode == MODE_AUTO || th_mode == MODE_MON) && period > elapsed) begin
      left = (period - elapsed) / 32'd1000;
      st.secs = (left > REM_MAX) ? REM_MAX : left[14:0];
    end
    st.relay = th_heat;
    st.mode = th_mode;
    st.reason = th_reason;
    st.fault = th_fault;
    return st;
  endfunction

  // one request: optional gap, hold valid until taken, then log the prediction
  task automatic send_request(input logic [2:0] req, input logic [31:0] now,
      input logic signed [11:0] temp, input logic sample_ok, input logic [2:0] idx);
    int             gap;
    heater_status_t st;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_now_ms <= now;
    in_temp_tenths <= temp;
    in_sample_valid <= sample_ok;
    in_profile_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    st = heater_status_after(req, now, temp, sample_ok, idx);
    status_due.push_back(st);
    reason_hits[st.reason]++;
    if (req <= REQ_MOFF) requests_sent++;
  endtask

  // drop valid and hold off until every outstanding status has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_MAX_TEMP:   cut_temp = data[11:0];
      CFG_SENSOR_TMO: sensor_limit_ms = data;
      CFG_MANUAL_TMO: manual_limit_ms = data;
      default: ;
    endcase
  endtask

  // new register setting, only written once the block has gone quiet
  task automatic configure(input logic signed [11:0] cut, input logic [31:0] sensor_ms,
      input logic [31:0] manual_ms);
    wait_results();
    write_reg(CFG_MAX_TEMP, {{20{cut[11]}}, cut});
    write_reg(CFG_SENSOR_TMO, sensor_ms);
    write_reg(CFG_MANUAL_TMO, manual_ms);
    write_reg(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // status before any tick, ignored samples and undefined request codes
  task automatic test_boot_and_ignored();
    send_request(REQ_SAMPLE, 32'd0, TEMP_MAX, 1'b0, 3'd0);
    send_request(REQ_UNDEF_LO, 32'd0, TEMP_MIN, 1'b1, 3'd7);
    send_request(REQ_UNDEF_HI, 32'd0, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_TICK, 32'd0, 12'sd0, 1'b0, 3'd0);
  endtask

  // every profile, rejected indexes, heat / band / hold and the end of a run
  task automatic test_auto_profiles();
    logic [2:0] p;
    wall_ms = 32'd1000;
    send_request(REQ_SAMPLE, wall_ms, TEMP_MIN, 1'b1, 3'd0);
    send_request(REQ_START, wall_ms, 12'sd0, 1'b0, 3'd6);
    send_request(REQ_START, wall_ms, 12'sd0, 1'b1, 3'd7);
    for (int i = 0; i < PROFILE_TOTAL; i++) begin
      p = 3'(i);
      wall_ms += 1;
      send_request(REQ_START, wall_ms, 12'sd0, 1'b0, p);
    end
    // last start is the longest profile, target 65.0 C
    wall_ms += 100;
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_SAMPLE, wall_ms, 12'sd640, 1'b1, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_SAMPLE, wall_ms, 12'sd650, 1'b1, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    wall_ms += 32'd21600000;
    send_request(REQ_SAMPLE, wall_ms, 12'sd300, 1'b1, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
  endtask

  // manual on, manual off and manual timeout
  task automatic test_manual_modes();
    wall_ms += 1000;
    send_request(REQ_MON, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_MOFF, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    wall_ms += 10;
    send_request(REQ_MON, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    wall_ms += 32'd3600001;
    send_request(REQ_SAMPLE, wall_ms, 12'sd300, 1'b1, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
  endtask

  // overtemperature, sticky sensor fault and a timestamp wrap
  task automatic test_safety_trips();
    send_request(REQ_SAMPLE, wall_ms, 12'sd700, 1'b1, 3'd0);
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    wall_ms += 32'd10001;
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
    send_request(REQ_SAMPLE, wall_ms, 12'sd100, 1'b0, 3'd0);
    wall_ms = 32'hFFFF_FF00;
    send_request(REQ_SAMPLE, wall_ms, 12'sd200, 1'b1, 3'd0);
    send_request(REQ_START, wall_ms, 12'sd0, 1'b0, 3'd2);
    wall_ms = 32'h0000_0100;
    send_request(REQ_TICK, wall_ms, 12'sd0, 1'b0, 3'd0);
  endtask

  // drying sessions: a command, then sample / tick pairs around its target
  task automatic run_sessions(input int quota);
    int                 goal;
    int                 kind;
    int                 steps;
    int                 aim;
    int                 wiggle;
    logic [2:0]         pidx;
    logic [31:0]        hop;
    logic signed [11:0] t;
    goal = requests_sent + quota;
    wall_ms = $urandom();
    while (requests_sent < goal) begin
      steady = ($urandom_range(0, 6) == 0);
      kind = $urandom_range(0, 19);
      pidx = 3'($urandom_range(0, PROFILE_TOTAL - 1));
      aim = profile_target[pidx];
      steps = $urandom_range(3, 30);
      if (kind < 10) begin
        // now and then a broken start with an index past the rom
        if ($urandom_range(0, 9) == 0) pidx = 3'($urandom_range(PROFILE_TOTAL, 7));
        send_request(REQ_START, wall_ms, 12'($urandom()), 1'($urandom()), pidx);
      end else if (kind < 15) begin
        send_request(REQ_MON, wall_ms, 12'($urandom()), 1'($urandom()), 3'($urandom()));
      end else if (kind < 17) begin
        send_request(REQ_MOFF, wall_ms, 12'($urandom()), 1'($urandom()), 3'($urandom()));
      end else begin
        // noise: any code, any field value, any timestamp
        send_request(3'($urandom()), $urandom(), 12'($urandom()), 1'($urandom()),
                     3'($urandom()));
        steps = 0;
      end
      repeat (steps) begin
        // mostly short hops, sometimes long enough to end a run or lose the sensor
        hop = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 25000000)
                                            : $urandom_range(20, 1500);
        wall_ms += hop;
        if ($urandom_range(0, 7) != 0) begin
          wiggle = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1650) - 400 + 60 - aim
                                                : $urandom_range(0, 90);
          t = 12'(aim + wiggle - 60);
          send_request(REQ_SAMPLE, wall_ms, t, 1'($urandom_range(0, 9) != 0),
                       3'($urandom()));
        end
        wall_ms += $urandom_range(0, 50);
        send_request(REQ_TICK, wall_ms, 12'($urandom()), 1'($urandom()), 3'($urandom()));
      end
      // occasional hold-off until the pipeline has drained
      if ($urandom_range(0, 40) == 0) wait_results();
    end
    steady = 1'b0;
  endtask

  // random sessions under several register settings, extremes included
  task automatic test_random_settings();
    configure(TEMP_MAX, 32'hFFFF_FFFF, 32'd0);
    run_sessions(350);
    configure(TEMP_MIN, 32'd0, 32'hFFFF_FFFF);
    run_sessions(200);
    repeat (2) begin
      configure(12'($urandom_range(450, 1000)), $urandom_range(500, 30000),
                $urandom_range(1000, 900000));
      run_sessions(450);
    end
    configure(MAX_TEMP_RST, SENSOR_TMO_RST, MANUAL_TMO_RST);
    run_sessions(450);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result side: random stall per result, compare against the oldest prediction
  initial begin : result_check
    int             stall;
    heater_status_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: status result with no request outstanding", $time);
      end else begin
        want = status_due.pop_front();
        check_field("relay_on", want.relay, out_relay_on);
        check_field("mode", want.mode, out_mode);
        check_field("reason", want.reason, out_reason);
        check_field("sensor_fault", want.fault, out_sensor_fault);
        check_field("remaining_s", want.secs, out_remaining_s);
        check_field("cmd_ok", want.ok, out_cmd_ok);
      end
    end
  end

  // watchdog on the whole run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("dryer_heater_thermostat_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_boot_and_ignored();
    test_auto_profiles();
    test_manual_modes();
    test_safety_trips();
    test_random_settings();
    wait_results();
    $display("covered %0d requests under %0d register settings, %0d results compared",
             requests_sent, settings_used, results_seen);
    $display("reasons reported: heating %0d, holding %0d, done %0d, overtemp %0d, timeout %0d",
             reason_hits[RSN_HEAT], reason_hits[RSN_HOLD], reason_hits[RSN_DONE],
             reason_hits[RSN_OVERTEMP], reason_hits[RSN_TIMEOUT]);
    if (errors == 0 && status_due.size() == 0) begin
      $display("dryer_heater_thermostat_unit regression: pass");
    end else begin
      $display("dryer_heater_thermostat_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dryth_pkg.sv
hw/rtl/dryth_core.sv
hw/rtl/dryth_rem.sv
hw/rtl/dryer_heater_thermostat_unit.sv
sim/dryer_heater_thermostat_unit_test.sv
